/* rtl/pdlf_pkg.sv */
// Shared types and constants for the directive line filter.
package pdlf_pkg;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    localparam logic [5:0] MAX_DEFERRED = 6'd62;
    localparam logic [6:0] MAX_RESULTS  = 7'd64;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [3:0] {
        MODE_START = 4'b0001,
        MODE_HASH  = 4'b0010,
        MODE_DIR   = 4'b0100,
        MODE_OTHER = 4'b1000
    } mode_t;

    // One item's output work: literal bytes first, then newlines up to total.
    typedef struct packed {
        logic [2:0][7:0] lit;
        logic [1:0]      nlit;
        logic [6:0]      total;
        logic            sat;
    } cmd_t;

endpackage

/* rtl/pdlf_front.sv */
// Front end: tracks line state per input item and produces output commands.
module pdlf_front
    import pdlf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       is_end,
    output logic       push,
    output cmd_t       push_cmd
);

    typedef struct packed {
        mode_t      mode;
        logic       emit;
        logic [7:0] ch;
        logic       end_dir;
    } pb_res_t;

    function automatic pb_res_t plain_step(mode_t m, logic [7:0] c);
        pb_res_t r;
        logic    blank;
        r.mode    = m;
        r.emit    = 1'b0;
        r.ch      = c;
        r.end_dir = 1'b0;
        blank     = (c == CH_SPACE) || (c == CH_TAB);
        unique case (m)
            MODE_START:
            begin
                if (!blank)
                begin
                    if (c == CH_HASH)
                    begin
                        r.emit = 1'b1;
                        r.mode = MODE_HASH;
                    end
                    else if (c == CH_LF)
                        r.emit = 1'b1;
                    else
                        r.mode = MODE_OTHER;
                end
            end
            MODE_HASH:
            begin
                if (!blank)
                begin
                    if (c == CH_LF)
                    begin
                        r.end_dir = 1'b1;
                        r.mode    = MODE_START;
                    end
                    else
                    begin
                        r.emit = 1'b1;
                        r.mode = MODE_DIR;
                    end
                end
            end
            MODE_DIR:
            begin
                if (c == CH_LF)
                begin
                    r.end_dir = 1'b1;
                    r.mode    = MODE_START;
                end
                else
                    r.emit = 1'b1;
            end
            MODE_OTHER:
            begin
                if (c == CH_LF)
                begin
                    r.emit = 1'b1;
                    r.mode = MODE_START;
                end
            end
            default:
                r.mode = MODE_START;
        endcase
        return r;
    endfunction

    mode_t      mode_reg, mode_next;
    logic       hb_reg, hb_next;
    logic       hcr_reg, hcr_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       sat_reg, sat_next;

    always_comb
    begin
        pb_res_t         r;
        logic [2:0][7:0] lit;
        logic [1:0]      nlit;
        logic [5:0]      nl;
        logic [6:0]      sum;
        logic            done;
        logic            cr;

        mode_next = mode_reg;
        hb_next   = hb_reg;
        hcr_next  = hcr_reg;
        cnt_next  = cnt_reg;
        sat_next  = sat_reg;
        lit       = '0;
        nlit      = 2'd0;
        nl        = 6'd0;
        done      = 1'b0;
        cr        = hcr_reg;
        r         = '0;

        if (is_end)
        begin
            if (hb_reg)
            begin
                r = plain_step(mode_next, CH_BSL);
                mode_next = r.mode;
                if (r.emit)
                begin
                    lit[nlit] = r.ch;
                    nlit = nlit + 2'd1;
                end
                if (cr)
                begin
                    r = plain_step(mode_next, CH_CR);
                    mode_next = r.mode;
                    if (r.emit)
                    begin
                        lit[nlit] = r.ch;
                        nlit = nlit + 2'd1;
                    end
                end
            end
            if (mode_next == MODE_HASH || mode_next == MODE_DIR)
                nl = cnt_reg;
            hb_next   = 1'b0;
            hcr_next  = 1'b0;
            cnt_next  = 6'd0;
            sat_next  = 1'b0;
            mode_next = MODE_START;
        end
        else
        begin
            if (hb_reg)
            begin
                if (in_byte == CH_LF)
                begin
                    hb_next  = 1'b0;
                    hcr_next = 1'b0;
                    done     = 1'b1;
                    if (mode_reg == MODE_HASH || mode_reg == MODE_DIR)
                    begin
                        if (cnt_reg < MAX_DEFERRED)
                            cnt_next = cnt_reg + 6'd1;
                        else
                            sat_next = 1'b1;
                    end
                    else
                    begin
                        lit[0] = CH_LF;
                        nlit   = 2'd1;
                    end
                end
                else if (in_byte == CH_CR && !hcr_reg)
                begin
                    hcr_next = 1'b1;
                    done     = 1'b1;
                end
                else
                begin
                    hb_next  = 1'b0;
                    hcr_next = 1'b0;
                    r = plain_step(mode_next, CH_BSL);
                    mode_next = r.mode;
                    if (r.emit)
                    begin
                        lit[nlit] = r.ch;
                        nlit = nlit + 2'd1;
                    end
                    if (cr)
                    begin
                        r = plain_step(mode_next, CH_CR);
                        mode_next = r.mode;
                        if (r.emit)
                        begin
                            lit[nlit] = r.ch;
                            nlit = nlit + 2'd1;
                        end
                    end
                end
            end
            if (!done)
            begin
                if (in_byte == CH_BSL)
                    hb_next = 1'b1;
                else
                begin
                    r = plain_step(mode_next, in_byte);
                    mode_next = r.mode;
                    if (r.emit)
                    begin
                        lit[nlit] = r.ch;
                        nlit = nlit + 2'd1;
                    end
                    if (r.end_dir)
                    begin
                        nl       = cnt_reg + 6'd1;
                        cnt_next = 6'd0;
                        sat_next = 1'b0;
                    end
                end
            end
        end

        sum = {5'd0, nlit} + {1'b0, nl};
        push_cmd.lit   = lit;
        push_cmd.nlit  = nlit;
        push_cmd.total = (sum > MAX_RESULTS) ? MAX_RESULTS : sum;
        push_cmd.sat   = sat_reg;
        push = accept && (sum != 7'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_START;
            hb_reg   <= 1'b0;
            hcr_reg  <= 1'b0;
            cnt_reg  <= 6'd0;
            sat_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            hb_reg   <= hb_next;
            hcr_reg  <= hcr_next;
            cnt_reg  <= cnt_next;
            sat_reg  <= sat_next;
        end
    end

endmodule

/* rtl/pdlf_queue.sv */
// Small command queue between front and back end.
module pdlf_queue
    import pdlf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t           mem [QDEPTH];
    logic [QAW-1:0] wr_reg;
    logic [QAW-1:0] rd_reg;
    logic [QAW:0]   cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (QAW+1)'(QDEPTH));
    assign head  = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

/* rtl/pdlf_back.sv */
// Back end: expands queued commands into output bytes, one per cycle unless out_ready stalls the output.
module pdlf_back
    import pdlf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       out_sat
);

    logic [6:0] pos_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       sat_reg;
    logic       load;
    logic       at_end;
    logic [7:0] cur_byte;

    assign load     = !valid_reg || out_ready;
    assign at_end   = (pos_reg + 7'd1) == head.total;
    assign cur_byte = (pos_reg < {5'd0, head.nlit}) ? head.lit[pos_reg[1:0]] : CH_LF;
    assign pop      = load && !empty && at_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= 7'd0;
        end
        else if (load)
        begin
            valid_reg <= !empty;
            if (!empty)
                pos_reg <= at_end ? 7'd0 : pos_reg + 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            byte_reg <= cur_byte;
            last_reg <= at_end;
            sat_reg  <= head.sat;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_sat   = sat_reg;

endmodule

/* rtl/preprocessor_directive_line_filter_top.sv */
// Directive line filter top level: stream in, filtered stream out.
// Takes one source byte per cycle while the command queue is not full and keeps
// preprocessor directive lines, replacing every other line by a newline. An
// input item may yield several output bytes (a directive's closing newline
// plus its deferred newlines, up to 64 bytes), which the output side sends
// one by one while later items are still taken in; the 4-entry command queue
// between the line tracker and the byte expander stalls input only once it
// fills. tlast marks the final output byte caused by one input item.
module preprocessor_directive_line_filter_top
    import pdlf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte
    input  logic       s_axis_tuser,   // is_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser    // saturated
);

    logic accept;
    logic push;
    cmd_t push_cmd;
    cmd_t head;
    logic empty;
    logic full;
    logic pop;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    pdlf_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (s_axis_tdata),
        .is_end   (s_axis_tuser),
        .push     (push),
        .push_cmd (push_cmd)
    );

    pdlf_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    pdlf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_sat   (m_axis_tuser)
    );

endmodule
